// ----- rtl/core/brd_pkg.sv -----
package brd_pkg;

    // Width of the output_limit register.
    localparam int LIMIT_W     = 24;
    // Width of the per-stream byte counter.
    localparam int COUNT_WIDTH = 24;
    // Effective limit needs one more bit: it may equal 2^COUNT_WIDTH.
    localparam int EFF_W       = COUNT_WIDTH + 1;

    localparam int VALUE_W     = 8;
    localparam int RUN_W       = 7;

    // Field sizes of the token syntax.
    localparam logic [3:0] RCOUNT_BITS = 4'd7;
    localparam logic [3:0] FIELD_BITS  = 4'd8;

    // Run queue between parser and output stage.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);

    typedef enum logic [2:0] {
        PH_FLAG   = 3'd0,
        PH_SKIP   = 3'd1,
        PH_RCOUNT = 3'd2,
        PH_RVALUE = 3'd3,
        PH_LCOUNT = 3'd4,
        PH_LBYTE  = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase       phase;
        logic [3:0]   gathered;
        logic [7:0]   shift;
        logic [6:0]   pending;
        logic [7:0]   lits;
    } t_parse;

    // Parser state at reset and at the start of every stream.
    localparam t_parse PARSE_RESET = '{phase: PH_FLAG, default: '0};

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RUN_W-1:0]   count;
        logic               last;
    } t_run;

    // Queue status seen by the front end.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Zero means 2^LIMIT_W; the result is also capped at 2^COUNT_WIDTH.
    function automatic logic [EFF_W-1:0] f_eff_limit(input logic [LIMIT_W-1:0] lim);
        logic [32:0] wide;
        logic [32:0] cap;
        wide = (lim == '0) ? (33'd1 << LIMIT_W) : 33'(lim);
        cap  = 33'd1 << COUNT_WIDTH;
        if (wide > cap) begin
            wide = cap;
        end
        return wide[EFF_W-1:0];
    endfunction

endpackage

// ----- rtl/core/brd_if.sv -----
interface brd_in_if;
    import brd_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] byte_in;
    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface brd_out_if;
    import brd_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [RUN_W-1:0]   repeat_count;
    logic               last_of_stream;
    modport source (output valid, output value, output repeat_count,
                    output last_of_stream, input ready);
    modport sink   (input valid, input value, input repeat_count,
                    input last_of_stream, output ready);
endinterface

interface brd_cfg_if;
    import brd_pkg::*;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] output_limit;
    modport source (output valid, output output_limit, input ready);
    modport sink   (input valid, input output_limit, output ready);
endinterface

// ----- rtl/core/bitpacked_rle_decoder.sv -----
// Bit-packed run-length decoder. Takes one compressed byte per cycle on i_in
// and emits run descriptors (value, repeat_count, last_of_stream) on o_out;
// a byte yields zero or one run. Sustained rate is one byte per cycle: the
// front end parses all eight bits of a byte through an unrolled bit chain and
// clips the run against the stream limit in the same cycle, so the only thing
// that throttles input is back-pressure, once the two-entry run queue and the
// output register are both full. A run is written into the run queue when its
// input byte is accepted, then moves on into the output register that drives
// o_out. Writing output_limit on i_cfg (always ready) also restarts the stream;
// write it only while the block is idle. A limit of zero means 2^24 bytes.
module bitpacked_rle_decoder (
    input  logic     i_clk,
    input  logic     i_rst_n,
    brd_in_if.sink   i_in,
    brd_cfg_if.sink  i_cfg,
    brd_out_if.source o_out
);
    import brd_pkg::*;

    // Front to queue
    logic   push;
    t_run   push_run;
    // Queue to back
    logic   pop;
    t_run   head_run;
    t_qstat qstat;

    // Front: token parser plus per-stream byte count and clipping.
    brd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_qstat (qstat),
        .o_push  (push),
        .o_run   (push_run)
    );

    // Short run queue decouples parsing from output stalls.
    brd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (push_run),
        .i_pop   (pop),
        .o_run   (head_run),
        .o_qstat (qstat)
    );

    // Back: registered output stage.
    brd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_run   (head_run),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/core/brd_front.sv -----
module brd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    brd_in_if.sink          i_in,
    brd_cfg_if.sink         i_cfg,
    input  brd_pkg::t_qstat i_qstat,
    output logic            o_push,
    output brd_pkg::t_run   o_run
);
    import brd_pkg::*;

    t_parse                 r_ps, n_ps;
    logic [COUNT_WIDTH-1:0] r_produced, n_produced;
    logic [EFF_W-1:0]       r_eff_limit;

    t_parse             ps_end;
    logic               found;
    logic [VALUE_W-1:0] run_value;
    logic [RUN_W-1:0]   run_count;
    logic [EFF_W-1:0]   remaining;
    logic               ended;
    logic               accept;

    assign i_in.ready  = !i_qstat.full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;

    // Unrolled bit chain: eight MSB-first steps of the token parser.
    always_comb begin : p_parse
        t_parse     st;
        logic       b;
        logic [7:0] sh_n;
        logic [3:0] g_n;
        st        = r_ps;
        found     = 1'b0;
        run_value = '0;
        run_count = '0;
        for (int i = 7; i >= 0; i--) begin
            b    = i_in.byte_in[i];
            sh_n = {st.shift[6:0], b};
            g_n  = st.gathered + 4'd1;
            case (st.phase)
                PH_FLAG: begin
                    st.phase    = b ? PH_SKIP : PH_LCOUNT;
                    st.gathered = '0;
                    st.shift    = '0;
                end
                PH_SKIP: begin
                    st.phase    = PH_RCOUNT;
                    st.gathered = '0;
                    st.shift    = '0;
                end
                PH_RCOUNT: begin
                    if (g_n >= RCOUNT_BITS) begin
                        st.pending  = sh_n[6:0];
                        st.phase    = PH_RVALUE;
                        st.gathered = '0;
                        st.shift    = '0;
                    end else begin
                        st.shift    = sh_n;
                        st.gathered = g_n;
                    end
                end
                PH_RVALUE: begin
                    if (g_n >= FIELD_BITS) begin
                        if (!found && st.pending != '0) begin
                            found     = 1'b1;
                            run_value = sh_n;
                            run_count = st.pending;
                        end
                        st.phase    = PH_FLAG;
                        st.gathered = '0;
                        st.shift    = '0;
                    end else begin
                        st.shift    = sh_n;
                        st.gathered = g_n;
                    end
                end
                PH_LCOUNT: begin
                    if (g_n >= FIELD_BITS) begin
                        st.lits     = sh_n;
                        st.phase    = (sh_n != '0) ? PH_LBYTE : PH_FLAG;
                        st.gathered = '0;
                        st.shift    = '0;
                    end else begin
                        st.shift    = sh_n;
                        st.gathered = g_n;
                    end
                end
                PH_LBYTE: begin
                    if (g_n >= FIELD_BITS) begin
                        if (!found) begin
                            found     = 1'b1;
                            run_value = sh_n;
                            run_count = RUN_W'(1);
                        end
                        st.lits     = st.lits - 8'd1;
                        st.phase    = (st.lits != '0) ? PH_LBYTE : PH_FLAG;
                        st.gathered = '0;
                        st.shift    = '0;
                    end else begin
                        st.shift    = sh_n;
                        st.gathered = g_n;
                    end
                end
                default: begin
                    st.phase    = PH_FLAG;
                    st.gathered = '0;
                    st.shift    = '0;
                end
            endcase
        end
        ps_end = st;
    end

    // Clip against the stream limit; ending a stream drops the rest of the byte.
    assign remaining = r_eff_limit - EFF_W'(r_produced);
    assign ended     = found && (EFF_W'(run_count) >= remaining);

    assign o_push        = accept && found;
    assign o_run.value   = run_value;
    assign o_run.count   = ended ? remaining[RUN_W-1:0] : run_count;
    assign o_run.last    = ended;

    always_comb begin
        n_ps       = r_ps;
        n_produced = r_produced;
        if (i_cfg.valid) begin
            n_ps       = PARSE_RESET;
            n_produced = '0;
        end else if (accept) begin
            if (ended) begin
                n_ps       = PARSE_RESET;
                n_produced = '0;
            end else begin
                n_ps       = ps_end;
                n_produced = r_produced + (found ? COUNT_WIDTH'(run_count) : '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps        <= PARSE_RESET;
            r_produced  <= '0;
            r_eff_limit <= f_eff_limit(LIMIT_RESET);
        end else begin
            r_ps       <= n_ps;
            r_produced <= n_produced;
            if (i_cfg.valid) begin
                r_eff_limit <= f_eff_limit(i_cfg.output_limit);
            end
        end
    end

endmodule

// ----- rtl/core/brd_queue.sv -----
module brd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  brd_pkg::t_run    i_run,
    input  logic             i_pop,
    output brd_pkg::t_run    o_run,
    output brd_pkg::t_qstat  o_qstat
);
    import brd_pkg::*;

    t_run              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              do_push, do_pop;

    assign o_qstat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_run         = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/core/brd_back.sv -----
module brd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  brd_pkg::t_qstat i_qstat,
    input  brd_pkg::t_run   i_run,
    output logic            o_pop,
    brd_out_if.source       o_out
);
    import brd_pkg::*;

    logic r_valid, n_valid;
    t_run r_run;

    // Refill the output register whenever it is empty or being drained.
    assign o_pop   = !i_qstat.empty && (!r_valid || o_out.ready);
    assign n_valid = o_pop ? 1'b1 : (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_run;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.value          = r_run.value;
    assign o_out.repeat_count   = r_run.count;
    assign o_out.last_of_stream = r_run.last;

endmodule

// ----- verif/tb_bitpacked_rle_decoder.sv -----
module tb_bitpacked_rle_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import brd_pkg::*;

    // Generous bound: ~900 bytes, with random input gaps and output stall bursts,
    // one long output hold-off and a few drain waits. It fits many times over.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles allowed after the last run before touching the limit register
    // (run queue, then output register; a token-ending byte may produce nothing).
    localparam int SETTLE      = 6;

    // ------------------------------------------------------------------
    // Run tracker: decodes every accepted byte in parallel with the DUT and
    // holds the runs that the DUT still owes.
    // ------------------------------------------------------------------
    class run_ledger;
        logic [LIMIT_W-1:0] out_limit;
        t_phase             phase;
        logic [3:0]         gathered;
        logic [7:0]         shreg;
        logic [6:0]         run_len;
        logic [7:0]         lits_left;
        longint unsigned    produced;
        t_run               runs_due[$];
        int                 errors;

        function new();
            out_limit = LIMIT_RESET;
            errors    = 0;
            restart();
        endfunction

        function void restart();
            phase     = PH_FLAG;
            gathered  = '0;
            shreg     = '0;
            run_len   = '0;
            lits_left = '0;
            produced  = 0;
        endfunction

        // A limit write also restarts the stream.
        function void write_limit(logic [LIMIT_W-1:0] v);
            out_limit = v;
            restart();
        endfunction

        function int outstanding();
            return runs_due.size();
        endfunction

        // Zero means 2^24; never more than the counter can hold.
        function longint unsigned stream_cap();
            longint unsigned lim;
            longint unsigned cap;
            lim = 64'(out_limit);
            if (out_limit == '0) begin
                lim = 64'd1 << LIMIT_W;
            end
            cap = 64'd1 << COUNT_WIDTH;
            return (lim > cap) ? cap : lim;
        endfunction

        function void open_field(t_phase nxt);
            phase    = nxt;
            gathered = '0;
            shreg    = '0;
        endfunction

        function bit shift_in(logic b, logic [3:0] width);
            shreg    = {shreg[6:0], b};
            gathered = gathered + 4'd1;
            return gathered >= width;
        endfunction

        // Clip against the stream limit; the run that hits it is marked last.
        function bit emit(logic [7:0] v, logic [6:0] n, output bit ended);
            longint unsigned remaining;
            t_run            r;
            ended = 1'b0;
            if (n == '0) begin
                return 1'b0;
            end
            remaining = stream_cap() - produced;
            r.value   = v;
            r.count   = n;
            r.last    = 1'b0;
            if (longint'(n) >= remaining) begin
                r.count = remaining[6:0];
                r.last  = 1'b1;
                restart();
                ended   = 1'b1;
            end else begin
                produced += 64'(n);
            end
            runs_due.insert(runs_due.size(), r);
            return 1'b1;
        endfunction

        // Walk the byte MSB first; stop early once the stream completes.
        function void take_byte(logic [7:0] b);
            logic       bv;
            logic [7:0] v;
            bit         ended;
            bit         got;
            ended = 1'b0;
            got   = 1'b0;
            for (int i = 7; i >= 0 && !ended; i--) begin
                bv = b[i];
                case (phase)
                    PH_FLAG: begin
                        if (bv) begin
                            open_field(PH_SKIP);
                        end else begin
                            open_field(PH_LCOUNT);
                        end
                    end
                    PH_SKIP: open_field(PH_RCOUNT);
                    PH_RCOUNT: begin
                        if (shift_in(bv, RCOUNT_BITS)) begin
                            run_len = shreg[6:0];
                            open_field(PH_RVALUE);
                        end
                    end
                    PH_RVALUE: begin
                        if (shift_in(bv, FIELD_BITS)) begin
                            v = shreg;
                            open_field(PH_FLAG);
                            if (!got) begin
                                got = emit(v, run_len, ended);
                            end
                        end
                    end
                    PH_LCOUNT: begin
                        if (shift_in(bv, FIELD_BITS)) begin
                            lits_left = shreg;
                            if (lits_left != '0) begin
                                open_field(PH_LBYTE);
                            end else begin
                                open_field(PH_FLAG);
                            end
                        end
                    end
                    PH_LBYTE: begin
                        if (shift_in(bv, FIELD_BITS)) begin
                            v         = shreg;
                            lits_left = lits_left - 8'd1;
                            if (lits_left != '0) begin
                                open_field(PH_LBYTE);
                            end else begin
                                open_field(PH_FLAG);
                            end
                            if (!got) begin
                                got = emit(v, 7'd1, ended);
                            end
                        end
                    end
                    default: open_field(PH_FLAG);
                endcase
            end
        endfunction

        function void match_run(logic [7:0] v, logic [6:0] n, logic last);
            t_run want;
            if (runs_due.size() == 0) begin
                $error("unexpected run: value=%0d repeat_count=%0d last_of_stream=%0d",
                       v, n, last);
                errors++;
                return;
            end
            want = runs_due.pop_front();
            if (v !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, v);
                errors++;
            end
            if (n !== want.count) begin
                $error("repeat_count: expected %0d, got %0d", want.count, n);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_stream: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    brd_in_if  byte_if ();
    brd_out_if run_if ();
    brd_cfg_if limit_if ();

    bitpacked_rle_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .i_cfg   (limit_if),
        .o_out   (run_if)
    );

    run_ledger ledger = new();

    // Stimulus knobs shared between the sender and the receiver.
    int gap_pct;      // chance (percent) that a byte is preceded by an idle burst
    bit quiet;        // no idling on either side
    int hold_req;     // one long output hold-off, in cycles
    int bytes_sent;
    int cycle_count;
    bit pend_bits[$]; // token bits not yet packed into a byte

    // ------------------------------------------------------------------
    // Monitor: every transfer is sampled at the edge that completes it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (run_if.valid && run_if.ready) begin
                ledger.match_run(run_if.value, run_if.repeat_count, run_if.last_of_stream);
            end
            if (limit_if.valid && limit_if.ready) begin
                ledger.write_limit(limit_if.output_limit);
            end
            if (byte_if.valid && byte_if.ready) begin
                ledger.take_byte(byte_if.byte_in);
            end
        end
    end

    // Run receiver: random stall bursts, plus one long hold-off on request so
    // the run queue fills and the DUT back-pressures its byte input.
    initial begin
        int burst;
        run_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                burst = hold_req;
                hold_req = 0;
                run_if.ready <= 1'b0;
                while (burst > 0) begin
                    @(posedge i_clk);
                    burst--;
                end
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 8);
                run_if.ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                run_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte sender and token builder
    // ------------------------------------------------------------------
    // Keeps valid high across back-to-back transfers; only drops it for a gap.
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.byte_in <= b;
        do @(posedge i_clk); while (!byte_if.ready);
        bytes_sent++;
    endtask

    task automatic end_input();
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void queue_bit(bit b);
        pend_bits.insert(pend_bits.size(), b);
    endfunction

    function automatic void put_bits(logic [7:0] val, int width);
        for (int k = width - 1; k >= 0; k--) begin
            queue_bit(val[k]);
        end
    endfunction

    function automatic void add_repeat(logic [6:0] n, logic [7:0] v);
        put_bits(8'd1, 1);
        put_bits(8'($urandom_range(0, 1)), 1);   // don't-care bit
        put_bits({1'b0, n}, 7);
        put_bits(v, 8);
    endfunction

    function automatic void add_literal_hdr(logic [7:0] n);
        put_bits(8'd0, 1);
        put_bits(n, 8);
    endfunction

    task automatic flush_bytes();
        logic [7:0] b;
        while (pend_bits.size() >= 8) begin
            for (int k = 7; k >= 0; k--) begin
                b[k] = pend_bits.pop_front();
            end
            send_byte(b);
        end
    endtask

    // Fill out the current byte with random bits, then send everything.
    task automatic pad_and_flush();
        while (pend_bits.size() % 8 != 0) begin
            queue_bit(1'($urandom_range(0, 1)));
        end
        flush_bytes();
    endtask

    // Mostly well-formed tokens with random content; some noise and cut-off tokens.
    task automatic random_bytes(input int n);
        int start;
        int pick;
        int cnt;
        int r;
        start = bytes_sent;
        while (bytes_sent - start < n) begin
            pick = $urandom_range(1, 100);
            if (pick <= 45) begin
                r = $urandom_range(1, 10);
                if (r == 1) begin
                    cnt = 0;
                end else if (r == 2) begin
                    cnt = 127;
                end else begin
                    cnt = $urandom_range(1, 126);
                end
                add_repeat(7'(cnt), 8'($urandom_range(0, 255)));
            end else if (pick <= 82) begin
                r = $urandom_range(1, 100);
                if (r <= 10) begin
                    cnt = 0;
                end else if (r <= 85) begin
                    cnt = $urandom_range(1, 4);
                end else if (r <= 98) begin
                    cnt = $urandom_range(5, 30);
                end else begin
                    cnt = $urandom_range(31, 255);
                end
                add_literal_hdr(8'(cnt));
                repeat (cnt) put_bits(8'($urandom_range(0, 255)), 8);
            end else if (pick <= 92) begin
                // raw noise
                repeat ($urandom_range(1, 12)) queue_bit(1'($urandom_range(0, 1)));
            end else begin
                // token header cut short; the rest parses as whatever follows
                put_bits(8'($urandom_range(0, 1)), 1);
                repeat ($urandom_range(1, 15)) queue_bit(1'($urandom_range(0, 1)));
            end
            flush_bytes();
        end
        pad_and_flush();
        end_input();
    endtask

    // Limit writes happen only once the DUT has nothing in flight.
    task automatic wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        wait_idle();
        limit_if.valid        <= 1'b1;
        limit_if.output_limit <= v;
        do @(posedge i_clk); while (!limit_if.ready);
        limit_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        byte_if.valid         <= 1'b0;
        byte_if.byte_in       <= '0;
        limit_if.valid        <= 1'b0;
        limit_if.output_limit <= '0;
        i_rst_n               <= 1'b0;
        gap_pct    = 20;
        quiet      = 1'b0;
        hold_req   = 0;
        bytes_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset limit: max repeat count and value, zero-count repeat,
        // count of one, empty literal, literal of extreme bytes, raw 00/FF.
        add_repeat(7'd127, 8'hFF);
        add_repeat(7'd0, 8'h55);
        add_repeat(7'd1, 8'h00);
        add_literal_hdr(8'd0);
        add_literal_hdr(8'd2);
        put_bits(8'h00, 8);
        put_bits(8'hFF, 8);
        pad_and_flush();
        put_bits(8'h00, 8);
        put_bits(8'hFF, 8);
        flush_bytes();
        end_input();

        // Limit of 3: a repeat clipped to the limit ends the stream and drops the
        // rest of its byte; then the limit is hit again by a literal/repeat mix.
        write_limit(24'd3);
        add_repeat(7'd5, 8'hA5);
        pad_and_flush();
        add_literal_hdr(8'd2);
        put_bits(8'h01, 8);
        put_bits(8'h80, 8);
        add_repeat(7'd1, 8'h7E);
        pad_and_flush();
        end_input();

        // Smallest limit: every run is last.
        write_limit(24'd1);
        gap_pct = 25;
        random_bytes(100);

        // Largest limit, with the long output hold-off.
        write_limit(24'hFF_FFFF);
        hold_req = 300;
        random_bytes(120);

        // Zero limit acts as 2^24.
        write_limit('0);
        gap_pct = 0;
        random_bytes(100);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: write_limit(LIMIT_W'($urandom_range(2, 40)));
                1: write_limit(LIMIT_W'($urandom_range(41, 600)));
                2: write_limit(LIMIT_W'($urandom_range(601, 5000)));
                default: write_limit(LIMIT_W'($urandom_range(1, 24'hFF_FFFF)));
            endcase
            gap_pct = (p % 2 == 1) ? 30 : 10;
            random_bytes(110);
        end

        // Closing stretch at full rate on both sides.
        quiet = 1'b1;
        write_limit(LIMIT_W'($urandom_range(20, 300)));
        random_bytes(100);

        wait_idle();
        if (ledger.errors == 0 && ledger.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
